/* hdl/spfd_pkg.sv */
// ----------------------------------------------------------------------------
// spfd_pkg
// Shared types and constants of the sensor pulse frame decoder.
// ----------------------------------------------------------------------------
package spfd_pkg;

   localparam int FRAME_BITS = 40;
   localparam int COUNT_WIDTH = $clog2(FRAME_BITS + 1);

   localparam logic [15:0] THRESHOLD_RESET = 16'd80;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_END   = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STS_VALID      = 2'd0,
      STS_CHECKSUM   = 2'd1,
      STS_INCOMPLETE = 2'd2
   } status_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] humidity;
      logic [15:0] temperature;
      status_type  status;
   } result_type;

endpackage

/* hdl/sensor_pulse_frame_decoder.sv */
// ----------------------------------------------------------------------------
// sensor_pulse_frame_decoder
// Decodes a single-wire sensor frame from edge timestamps into humidity,
// temperature and a status code.
//
// req channel: one item per command (begin frame, edge captured, end of
// window); tuser carries the command, tdata the 32-bit capture time.
// rsp channel: one item when a frame completes (40 bits) or ends early;
// tdata carries humidity and temperature, tuser the status.
// csr channel: writes the 16-bit bit threshold; always ready.
// A req item is held in the input register, its result in the rsp register.
// Throughput: one item per cycle unless rsp stalls, set by the single decode
// stage between the input register and the result register.
// Reset clears the frame, the last valid values and the threshold (to 80).
// While rsp is stalled with a result held, the input register holds its
// item and req_tready falls once it is full.
// ----------------------------------------------------------------------------
module sensor_pulse_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] capture_time
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] humidity, [31:16] temperature
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_cmd_ff;
   logic [31:0] s1_time_ff;
   logic [15:0] threshold_ff, threshold_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic        out_free;
   logic        advance;
   logic        take;

   spfd_pkg::result_type result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign s1_valid_in  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign threshold_in = csr_valid ? csr_data : threshold_ff;
   assign rsp_valid_in = (advance && result.valid) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   spfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .cmd       (s1_cmd_ff),
      .ctime     (s1_time_ff),
      .threshold (threshold_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= spfd_pkg::THRESHOLD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff  <= req_tuser;
         s1_time_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         rsp_data_ff <= {result.temperature, result.humidity};
         rsp_user_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* hdl/spfd_core.sv */
// ----------------------------------------------------------------------------
// spfd_core
// Frame state and per-item decode: interval, bit shift, sum and checksum.
// ----------------------------------------------------------------------------
module spfd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [1:0]             cmd,
   input  logic [31:0]            ctime,
   input  logic [15:0]            threshold,
   output spfd_pkg::result_type   result
);

   localparam int CW = spfd_pkg::COUNT_WIDTH;

   logic [31:0]   prev_ff, prev_in;
   logic          have_ref_ff, have_ref_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   data_ff, data_in;
   logic [7:0]    check_ff, check_in;
   logic [7:0]    sum_ff, sum_in;
   logic          done_ff, done_in;
   logic [15:0]   hum_ff, hum_in;
   logic [15:0]   temp_ff, temp_in;

   logic [31:0]   interval;
   logic          new_bit;
   logic [CW-1:0] count_inc;
   logic [CW:0]   count_plus;
   logic [14:0]   mag;

   assign interval   = ctime - prev_ff;
   assign new_bit    = (interval >= {16'd0, threshold});
   assign count_inc  = count_ff + CW'(1);
   assign count_plus = {1'b0, count_inc} + (CW+1)'(8);
   assign mag        = data_in[14:0];

   always_comb begin
      prev_in     = prev_ff;
      have_ref_in = have_ref_ff;
      count_in    = count_ff;
      data_in     = data_ff;
      check_in    = check_ff;
      sum_in      = sum_ff;
      done_in     = done_ff;
      hum_in      = hum_ff;
      temp_in     = temp_ff;
      result      = '{valid: 1'b0, humidity: hum_ff, temperature: temp_ff,
                      status: spfd_pkg::STS_VALID};
      if (fire) begin
         case (cmd)
            spfd_pkg::CMD_BEGIN: begin
               prev_in     = '0;
               have_ref_in = 1'b0;
               count_in    = '0;
               data_in     = '0;
               check_in    = '0;
               sum_in      = '0;
               done_in     = 1'b0;
            end
            spfd_pkg::CMD_END: begin
               if (!done_ff) begin
                  done_in       = 1'b1;
                  result.valid  = 1'b1;
                  result.status = spfd_pkg::STS_INCOMPLETE;
               end
            end
            spfd_pkg::CMD_EDGE: begin
               if (!done_ff) begin
                  prev_in = ctime;
                  if (!have_ref_ff) begin
                     have_ref_in = 1'b1;
                  end else begin
                     data_in  = {data_ff[30:0], check_ff[7]};
                     check_in = {check_ff[6:0], new_bit};
                     count_in = count_inc;
                     if (count_inc[2:0] == 3'd0 &&
                         count_plus <= (CW+1)'(spfd_pkg::FRAME_BITS)) begin
                        sum_in = sum_ff + check_in;
                     end
                     if (count_inc >= CW'(spfd_pkg::FRAME_BITS)) begin
                        done_in       = 1'b1;
                        result.valid  = 1'b1;
                        result.status = spfd_pkg::STS_CHECKSUM;
                        if (sum_in == check_in) begin
                           hum_in  = data_in[31:16];
                           temp_in = data_in[15] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
                           result.status = spfd_pkg::STS_VALID;
                        end
                        result.humidity    = hum_in;
                        result.temperature = temp_in;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         have_ref_ff <= 1'b0;
         count_ff    <= '0;
         data_ff     <= '0;
         check_ff    <= '0;
         sum_ff      <= '0;
         done_ff     <= 1'b0;
         hum_ff      <= '0;
         temp_ff     <= '0;
      end else begin
         prev_ff     <= prev_in;
         have_ref_ff <= have_ref_in;
         count_ff    <= count_in;
         data_ff     <= data_in;
         check_ff    <= check_in;
         sum_ff      <= sum_in;
         done_ff     <= done_in;
         hum_ff      <= hum_in;
         temp_ff     <= temp_in;
      end
   end

endmodule

/* hdl/spfd_checker.sv */
// ----------------------------------------------------------------------------
// spfd_checker
// Port-level checks of the sensor pulse frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module spfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp item changed");

   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp item without a req item two cycles earlier");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == spfd_pkg::STS_VALID ||
                      rsp_tuser == spfd_pkg::STS_CHECKSUM ||
                      rsp_tuser == spfd_pkg::STS_INCOMPLETE))
      else $error("undefined status code");

   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind sensor_pulse_frame_decoder spfd_checker u_spfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
